/* rtl/upd_pkg.sv */
// Package for the URL percent decoder: phase encoding, result and push types,
// queue sizing and the hex digit lookup. No dependencies.
`default_nettype none

package upd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned NIBBLE_W   = 4;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PUSH_NONE = 2'd0,
        PUSH_ONE  = 2'd1,
        PUSH_TWO  = 2'd2
    } push_cnt_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
    } result_t;

    typedef struct packed {
        push_cnt_t cnt;
        result_t   r0;
        result_t   r1;
    } push_t;

    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] val;
    } hex_t;

    function automatic hex_t hex_value(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = NIBBLE_W'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.val = NIBBLE_W'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.val = NIBBLE_W'(c - 8'h57);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* rtl/upd_in_if.sv */
// Input channel of the URL percent decoder: valid/ready plus one encoded byte.
// Depends on upd_pkg for widths.
`default_nettype none

interface upd_in_if;
    logic                       valid;
    logic                       ready;
    logic [upd_pkg::BYTE_W-1:0] in_byte;
    logic                       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

/* rtl/upd_out_if.sv */
// Output channel of the URL percent decoder: valid/ready plus one decoded byte.
// Depends on upd_pkg for widths.
`default_nettype none

interface upd_out_if;
    logic                       valid;
    logic                       ready;
    logic [upd_pkg::BYTE_W-1:0] out_byte;
    logic                       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/upd_decode.sv */
// Input register and escape decoder: holds the phase and the first hex digit,
// and turns each transaction into zero, one or two results. Depends on upd_pkg, upd_in_if.
`default_nettype none

module upd_decode
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    upd_in_if.sink         in_item,
    input  wire logic      room,
    output upd_pkg::push_t push
);

    logic                         s1_valid_reg;
    logic [upd_pkg::BYTE_W-1:0]   s1_byte_reg;
    logic                         s1_last_reg;
    logic                         fire;
    logic                         accept;

    upd_pkg::phase_t              phase_reg;
    upd_pkg::phase_t              phase_next;
    logic [upd_pkg::NIBBLE_W-1:0] held_reg;
    logic [upd_pkg::NIBBLE_W-1:0] held_next;

    upd_pkg::hex_t                hex;
    logic                         is_pct;
    logic [upd_pkg::BYTE_W-1:0]   plain_byte;
    upd_pkg::push_t               push_raw;

    assign fire          = s1_valid_reg & room;
    assign in_item.ready = ~s1_valid_reg | room;
    assign accept        = in_item.valid & in_item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_item.ready)
        begin
            s1_valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= in_item.in_byte;
            s1_last_reg <= in_item.in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upd_pkg::PH_PLAIN;
            held_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    assign hex        = upd_pkg::hex_value(s1_byte_reg);
    assign is_pct     = (s1_byte_reg == upd_pkg::CHAR_PERCENT);
    assign plain_byte = (s1_byte_reg == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : s1_byte_reg;

    // next phase
    always_comb
    begin
        phase_next = upd_pkg::PH_PLAIN;
        held_next  = held_reg;
        unique case (phase_reg)
            upd_pkg::PH_PCT:
            begin
                if (hex.ok)
                begin
                    if (!s1_last_reg)
                    begin
                        held_next  = hex.val;
                        phase_next = upd_pkg::PH_DIGIT;
                    end
                end
                else if (is_pct)
                begin
                    phase_next = upd_pkg::PH_PCT;
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (!hex.ok && is_pct)
                begin
                    phase_next = upd_pkg::PH_PCT;
                end
            end
            default:
            begin
                if (is_pct)
                begin
                    phase_next = upd_pkg::PH_PCT;
                end
            end
        endcase
        if (s1_last_reg)
        begin
            phase_next = upd_pkg::PH_PLAIN;
        end
    end

    // results
    always_comb
    begin
        push_raw.cnt         = upd_pkg::PUSH_NONE;
        push_raw.r0.out_byte = plain_byte;
        push_raw.r0.run_last = 1'b0;
        push_raw.r1.out_byte = plain_byte;
        push_raw.r1.run_last = 1'b0;
        unique case (phase_reg)
            upd_pkg::PH_PCT:
            begin
                if (hex.ok)
                begin
                    if (s1_last_reg)
                    begin
                        push_raw.cnt         = upd_pkg::PUSH_ONE;
                        push_raw.r0.out_byte = upd_pkg::BYTE_W'(hex.val);
                    end
                end
                else if (!is_pct)
                begin
                    push_raw.cnt = upd_pkg::PUSH_ONE;
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (hex.ok)
                begin
                    push_raw.cnt         = upd_pkg::PUSH_ONE;
                    push_raw.r0.out_byte = {held_reg, hex.val};
                end
                else
                begin
                    push_raw.r0.out_byte = upd_pkg::BYTE_W'(held_reg);
                    push_raw.cnt         = is_pct ? upd_pkg::PUSH_ONE : upd_pkg::PUSH_TWO;
                end
            end
            default:
            begin
                if (!is_pct)
                begin
                    push_raw.cnt = upd_pkg::PUSH_ONE;
                end
            end
        endcase
        push_raw.r0.run_last = (push_raw.cnt == upd_pkg::PUSH_ONE);
        push_raw.r1.run_last = (push_raw.cnt == upd_pkg::PUSH_TWO);
        if (!fire)
        begin
            push_raw.cnt = upd_pkg::PUSH_NONE;
        end
    end

    assign push = push_raw;

endmodule

`default_nettype wire

/* rtl/upd_outq.sv */
// Result queue: takes up to two results per cycle, drives one per transaction
// on the output channel. Depends on upd_pkg, upd_out_if.
`default_nettype none

module upd_outq
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire upd_pkg::push_t push,
    output logic                room,
    upd_out_if.source           out_item
);

    upd_pkg::result_t            mem_reg [upd_pkg::QUEUE_DEPTH];
    logic [upd_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [upd_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [upd_pkg::QPTR_W-1:0]  wr_ptr_alt;
    logic [upd_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [upd_pkg::QCNT_W-1:0]  count_reg;
    logic [upd_pkg::QCNT_W-1:0]  count_next;
    logic                        pop;
    logic [upd_pkg::QCNT_W-1:0]  push_n;

    assign room     = (count_reg <= upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH - 2));
    assign pop      = out_item.valid & out_item.ready;
    assign push_n   = upd_pkg::QCNT_W'(push.cnt);
    assign wr_ptr_alt  = wr_ptr_reg + upd_pkg::QPTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + upd_pkg::QPTR_W'(push_n);
    assign count_next  = count_reg + push_n - upd_pkg::QCNT_W'(pop);

    assign out_item.valid    = (count_reg != '0);
    assign out_item.out_byte = mem_reg[rd_ptr_reg].out_byte;
    assign out_item.run_last = mem_reg[rd_ptr_reg].run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + upd_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != upd_pkg::PUSH_NONE)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == upd_pkg::PUSH_TWO)
        begin
            mem_reg[wr_ptr_alt] <= push.r1;
        end
    end

endmodule

`default_nettype wire

/* rtl/url_percent_decoder_core.sv */
// URL percent decoder top level: input register and decoder feeding a 4-entry result queue.
// An accepted byte passes the input register, then the result queue, on its way to the output.
// Throughput: one input byte per cycle while the queue has room for two results; the
// decoder stalls otherwise. A bad escape's second result takes its own output transfer.
// Reset: rst_n clears the phase to plain text, the held digit and the queue.
// Depends on upd_pkg, upd_in_if, upd_out_if, upd_decode, upd_outq.
`default_nettype none

module url_percent_decoder_core
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    upd_in_if.sink     in_item,
    upd_out_if.source  out_item
);

    upd_pkg::push_t push;
    logic           room;

    upd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .room    (room),
        .push    (push)
    );

    upd_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

/* verif/url_percent_decoder_core_tb.sv */
// Self-checking testbench for url_percent_decoder_core: directed escapes, then random
// encoded strings under bursty input and stalling output, checked against a local decoder.
// Depends on upd_pkg, upd_in_if, upd_out_if and the RTL of url_percent_decoder_core.
module url_percent_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 525;
    localparam int IDLE_LIMIT   = 1000;
    localparam int LONG_HOLD    = 100;

    typedef struct {
        logic [7:0] enc_byte;
        logic       enc_last;
        bit         wait_empty;
    } enc_item_t;

    logic clk = 1'b0;
    logic rst_n;

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    url_percent_decoder_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    always
    begin
        #5 clk = ~clk;
    end

    enc_item_t          pending_q[$];
    upd_pkg::result_t   decoded_q[$];
    upd_pkg::phase_t    dec_phase;
    logic [3:0]         dec_nibble;
    int                 total_items;
    int                 in_accepted;
    int                 fail_cnt;
    int                 burst_left;
    int                 gap_left;
    int                 stall_mode;
    int                 mode_left;
    int                 hold_left;
    bit                 long_hold_done;
    int                 idle_cycles;
    enc_item_t          next_item;
    upd_pkg::result_t   want;

    function automatic int nibble_of(logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return int'(c) - 'h30;
        end
        if (folded >= 8'h61 && folded <= 8'h66)
        begin
            return int'(folded) - 'h57;
        end
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(int v, bit upper);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        return upper ? 8'(8'h37 + v) : 8'(8'h57 + v);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (nibble_of(b) >= 0)
        begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        return hex_char(int'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic push_decoded(logic [7:0] b, inout int n);
        upd_pkg::result_t r;
        r.out_byte = b;
        r.run_last = 1'b0;
        decoded_q.insert(decoded_q.size(), r);
        n++;
    endtask

    task automatic take_plain(logic [7:0] b, logic l, inout int n);
        if (b == upd_pkg::CHAR_PERCENT)
        begin
            dec_phase = l ? upd_pkg::PH_PLAIN : upd_pkg::PH_PCT;
        end
        else
        begin
            push_decoded((b == upd_pkg::CHAR_PLUS) ? upd_pkg::CHAR_SPACE : b, n);
            dec_phase = upd_pkg::PH_PLAIN;
        end
    endtask

    task automatic decode_byte(logic [7:0] b, logic l);
        int h;
        int n;
        h = nibble_of(b);
        n = 0;
        case (dec_phase)
            upd_pkg::PH_PCT:
            begin
                if (h >= 0 && l)
                begin
                    push_decoded(8'(h), n);
                    dec_phase = upd_pkg::PH_PLAIN;
                end
                else if (h >= 0)
                begin
                    dec_nibble = 4'(h);
                    dec_phase  = upd_pkg::PH_DIGIT;
                end
                else
                begin
                    take_plain(b, l, n);
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (h >= 0)
                begin
                    push_decoded({dec_nibble, 4'(h)}, n);
                    dec_phase = upd_pkg::PH_PLAIN;
                end
                else
                begin
                    push_decoded({4'h0, dec_nibble}, n);
                    take_plain(b, l, n);
                end
            end
            default:
            begin
                take_plain(b, l, n);
            end
        endcase
        if (l)
        begin
            dec_phase = upd_pkg::PH_PLAIN;
        end
        if (n > 0)
        begin
            decoded_q[decoded_q.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic add_byte(logic [7:0] b, logic l, bit wait_empty = 1'b0);
        enc_item_t it;
        it.enc_byte   = b;
        it.enc_last   = l;
        it.wait_empty = wait_empty;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic add_string(bit wait_empty);
        logic [7:0] s[$];
        int pieces;
        int r;
        pieces = $urandom_range(1, 10);
        for (int i = 0; i < pieces; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
            else if (r < 50)
            begin
                s.insert(s.size(), upd_pkg::CHAR_PLUS);
            end
            else if (r < 80)
            begin
                s.insert(s.size(), upd_pkg::CHAR_PERCENT);
                s.insert(s.size(), rand_hex_char());
                s.insert(s.size(), rand_hex_char());
            end
            else if (r < 86)
            begin
                s.insert(s.size(), upd_pkg::CHAR_PERCENT);
                s.insert(s.size(), non_hex_byte());
            end
            else if (r < 92)
            begin
                s.insert(s.size(), upd_pkg::CHAR_PERCENT);
                s.insert(s.size(), rand_hex_char());
                s.insert(s.size(), non_hex_byte());
            end
            else if (r < 96)
            begin
                s.insert(s.size(), upd_pkg::CHAR_PERCENT);
                s.insert(s.size(), upd_pkg::CHAR_PERCENT);
            end
            else
            begin
                s.insert(s.size(), upd_pkg::CHAR_PERCENT);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            s.insert(s.size(), upd_pkg::CHAR_PERCENT);
            s.insert(s.size(), rand_hex_char());
        end
        else if (r < 25)
        begin
            s.insert(s.size(), upd_pkg::CHAR_PERCENT);
        end
        foreach (s[i])
        begin
            add_byte(s[i], i == s.size() - 1, wait_empty && i == 0);
        end
    endtask

    // driver: bursts with random gaps, hold until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.in_byte <= '0;
            in_ch.in_last <= 1'b0;
            burst_left    = 0;
            gap_left      = 0;
            in_accepted   = 0;
            dec_phase     = upd_pkg::PH_PLAIN;
            dec_nibble    = '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                decode_byte(in_ch.in_byte, in_ch.in_last);
                in_accepted++;
            end
            if (in_ch.valid && !in_ch.ready)
            begin
                in_ch.valid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_q.size() == 0
                     || (pending_q[0].wait_empty && decoded_q.size() != 0))
            begin
                in_ch.valid <= 1'b0;
            end
            else
            begin
                next_item = pending_q.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.in_byte <= next_item.enc_byte;
                in_ch.in_last <= next_item.enc_last;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // monitor: check results, stall on its own pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready   <= 1'b0;
            stall_mode     = 0;
            mode_left      = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result: out_byte %h run_last %b",
                           out_ch.out_byte, out_ch.run_last);
                    fail_cnt++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, out_ch.out_byte);
                        fail_cnt++;
                    end
                    if (out_ch.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, actual %b",
                               want.run_last, out_ch.run_last);
                        fail_cnt++;
                    end
                end
            end
            if (!long_hold_done && in_accepted >= 300)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog: end the run when nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("url_percent_decoder_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        fail_cnt      = 0;
        idle_cycles   = 0;

        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(upd_pkg::CHAR_PLUS, 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("A", 1'b0);
        add_byte("0", 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("f", 1'b0);
        add_byte("9", 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("G", 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("4", 1'b0);
        add_byte(upd_pkg::CHAR_PLUS, 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("a", 1'b0);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("F", 1'b1);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b1);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte("c", 1'b0);
        add_byte("Z", 1'b1);
        add_byte(upd_pkg::CHAR_PERCENT, 1'b0);
        add_byte(upd_pkg::CHAR_PLUS, 1'b1);

        while (pending_q.size() < RANDOM_ITEMS + 25)
        begin
            add_string(pending_q.size() == 25
                       || (pending_q.size() > 450 && pending_q.size() < 460));
        end
        total_items = pending_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (in_accepted < total_items)
        begin
            @(posedge clk);
        end
        while (decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (fail_cnt == 0)
        begin
            $display("url_percent_decoder_core regression: pass");
        end
        else
        begin
            $display("url_percent_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
